/* hw/rtl/assert_macros.svh */
// Assertion helpers for the stereo decision block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define ASSERT_NEVER(label, clk, rst_n, expr, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);
`else
`define ASSERT_CLK(label, clk, rst_n, prop, msg)
`define ASSERT_NEVER(label, clk, rst_n, expr, msg)
`endif
`endif

/* hw/rtl/mssbd_pkg.sv */
// ----------------------------------------------------------------------------
// mssbd_pkg
// Types and constants shared by the stereo band decision block.
// ----------------------------------------------------------------------------
`default_nettype none
package mssbd_pkg;
  localparam int EW = 32;
  localparam int SW = 32;
  localparam int QDEPTH = 2;

  localparam logic [1:0] FUNC_BAND = 2'd0;
  localparam logic [1:0] FUNC_LINE = 2'd1;
  localparam logic [1:0] FUNC_END  = 2'd2;
  localparam logic [1:0] FUNC_RSVD = 2'd3;

  localparam logic [1:0] SEL_NONE = 2'd0;
  localparam logic [1:0] SEL_MIXED = 2'd1;
  localparam logic [1:0] SEL_ALL = 2'd2;

  typedef struct packed {
    logic [1:0]           func;
    logic [31:0]          energy_left;
    logic [31:0]          energy_right;
    logic [31:0]          energy_mid;
    logic [31:0]          energy_side;
    logic [31:0]          thr_left;
    logic [31:0]          thr_right;
    logic [31:0]          spread_left;
    logic [31:0]          spread_right;
    logic signed [31:0]   line_left;
    logic signed [31:0]   line_right;
  } in_item_t;

  typedef struct packed {
    logic                 band_use_ms;
    logic [31:0]          thr_left_out;
    logic [31:0]          thr_right_out;
    logic [31:0]          energy_left_out;
    logic [31:0]          energy_right_out;
    logic [31:0]          spread_out;
    logic signed [31:0]   line_left_out;
    logic signed [31:0]   line_right_out;
    logic [1:0]           frame_mode;
  } out_item_t;

  // Classified command handed from front to back.
  typedef struct packed {
    logic [1:0]    func;
    logic          zero_den;
    logic [EW-1:0] m;
    logic [EW-1:0] a;
    logic [EW-1:0] b;
    logic [EW-1:0] c;
    logic [EW-1:0] d;
    logic [EW-1:0] el;
    logic [EW-1:0] er;
    logic [EW-1:0] em;
    logic [EW-1:0] es;
    logic [EW-1:0] tl;
    logic [EW-1:0] tr;
    logic [EW-1:0] sl;
    logic [EW-1:0] sr;
    logic [SW-1:0] ll;
    logic [SW-1:0] lr;
  } cmd_t;

  typedef enum logic [2:0] {
    BK_IDLE, BK_P1, BK_P2, BK_LW, BK_P3, BK_P4, BK_RW, BK_DONE
  } bk_state_t;
endpackage
`default_nettype wire

/* hw/rtl/ms_stereo_band_decision_top.sv */
// ----------------------------------------------------------------------------
// ms_stereo_band_decision_top
// Mid/side versus left/right stereo decision per scale-factor band.
// ----------------------------------------------------------------------------
// Every item gives one result. A band item holds the back end through the
// dequeue, four 32x32 products for the 64-bit terms, eight partial products
// that build the two 128-bit sides of the compare, and the result; line and
// end items go from the dequeue straight to the result. The back end pops a
// new command only once it is idle again. A two-entry command queue
// separates intake from the back end, and the result register holds a
// stalled result.
`default_nettype none
module ms_stereo_band_decision_top import mssbd_pkg::*; (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_valid,
  output logic           in_stall,
  input  wire in_item_t  in_data,
  output logic           out_valid,
  input  wire logic      out_stall,
  output out_item_t      out_data
);
  logic q_valid, q_pop;
  cmd_t q_data;

  mssbd_front u_front (
    .clk, .rst_n, .in_valid, .in_stall, .in_data,
    .q_valid, .q_pop, .q_data
  );

  mssbd_back u_back (
    .clk, .rst_n, .q_valid, .q_pop, .q_data,
    .out_valid, .out_stall, .out_data
  );
endmodule
`default_nettype wire

/* hw/rtl/mssbd_front.sv */
// ----------------------------------------------------------------------------
// mssbd_front
// Accepts items, computes the band maxima and minimum, and queues commands.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"
module mssbd_front import mssbd_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_valid,
  output logic          in_stall,
  input  wire in_item_t in_data,
  output logic          q_valid,
  input  wire logic     q_pop,
  output cmd_t          q_data
);
  cmd_t       mem_r [QDEPTH];
  logic       wp_r, wp_nxt, rp_r, rp_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  cmd_t       c;
  logic       push;

  always_comb begin
    c.func = in_data.func;
    c.el = in_data.energy_left[EW-1:0];
    c.er = in_data.energy_right[EW-1:0];
    c.em = in_data.energy_mid[EW-1:0];
    c.es = in_data.energy_side[EW-1:0];
    c.tl = in_data.thr_left[EW-1:0];
    c.tr = in_data.thr_right[EW-1:0];
    c.sl = in_data.spread_left[EW-1:0];
    c.sr = in_data.spread_right[EW-1:0];
    c.ll = in_data.line_left[SW-1:0];
    c.lr = in_data.line_right[SW-1:0];
    c.m = (c.tl < c.tr) ? c.tl : c.tr;
    c.a = (c.el > c.tl) ? c.el : c.tl;
    c.b = (c.er > c.tr) ? c.er : c.tr;
    c.c = (c.em > c.m) ? c.em : c.m;
    c.d = (c.es > c.m) ? c.es : c.m;
    c.zero_den = (c.a == '0) || (c.b == '0) || (c.c == '0) || (c.d == '0);
  end

  assign in_stall = (cnt_r == 2'(QDEPTH));
  assign push = in_valid && !in_stall;
  assign q_valid = (cnt_r != 2'd0);
  assign q_data = mem_r[rp_r];

  always_comb begin
    wp_nxt = push ? ~wp_r : wp_r;
    rp_nxt = q_pop ? ~rp_r : rp_r;
    cnt_nxt = cnt_r + {1'b0, push} - {1'b0, q_pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= 1'b0;
      rp_r <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      wp_r <= wp_nxt;
      rp_r <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wp_r] <= c;
  end

  `ASSERT_NEVER(a_q_over, clk, rst_n, cnt_r > 2'(QDEPTH), "queue count overflow")
  `ASSERT_NEVER(a_q_under, clk, rst_n, q_pop && cnt_r == 2'd0, "pop from empty queue")
  `ASSERT_CLK(a_q_cnt, clk, rst_n, push && !q_pop |=> cnt_r == $past(cnt_r) + 2'd1, "queue count did not follow push")
endmodule
`default_nettype wire

/* hw/rtl/mssbd_back.sv */
// ----------------------------------------------------------------------------
// mssbd_back
// Runs the cross-multiplied compare on one shared multiplier and forms results.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"
module mssbd_back import mssbd_pkg::*; (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic q_valid,
  output logic      q_pop,
  input  wire cmd_t q_data,
  output logic      out_valid,
  input  wire logic out_stall,
  output out_item_t out_data
);
  bk_state_t   st_r, st_nxt;
  cmd_t        cmd_r;
  logic [1:0]  pp_r, pp_nxt;
  logic [2*EW-1:0] p1_r, p2_r, p_nxt;
  logic [EW-1:0]   ma, mb;
  logic [4*EW-1:0] lhs_r, rhs_r, part, acc_base, acc_nxt;
  logic        ms_r, seen_ms_r, seen_lr_r;
  logic        ms_nxt, seen_ms_nxt, seen_lr_nxt;
  logic        ov_r, ov_nxt;
  out_item_t   od_r, od_nxt;
  logic        take;
  logic        dec;
  logic signed [SW:0] sum, dif;
  logic [EW-1:0] smin;

  assign out_valid = ov_r;
  assign out_data = od_r;
  assign take = !ov_r || !out_stall;

  // One 32x32 product per cycle. P1..P4 form the four 64-bit terms; LW and
  // RW each sum the four partial products of one 128-bit side.
  always_comb begin
    ma = '0;
    mb = '0;
    unique case (st_r)
      BK_P1: begin ma = cmd_r.m; mb = cmd_r.m; end
      BK_P2: begin ma = cmd_r.a; mb = cmd_r.b; end
      BK_P3: begin ma = cmd_r.tl; mb = cmd_r.tr; end
      BK_P4: begin ma = cmd_r.c; mb = cmd_r.d; end
      BK_LW, BK_RW: begin
        ma = pp_r[1] ? p1_r[2*EW-1:EW] : p1_r[EW-1:0];
        mb = pp_r[0] ? p2_r[2*EW-1:EW] : p2_r[EW-1:0];
      end
      BK_IDLE, BK_DONE: begin ma = '0; mb = '0; end
    endcase
    p_nxt = ma * mb;
    unique case (pp_r)
      2'd0: part = {{2*EW{1'b0}}, p_nxt};
      2'd1, 2'd2: part = {{EW{1'b0}}, p_nxt, {EW{1'b0}}};
      2'd3: part = {p_nxt, {2*EW{1'b0}}};
    endcase
    acc_base = (st_r == BK_RW) ? rhs_r : lhs_r;
    if (pp_r == 2'd0) acc_base = '0;
    acc_nxt = acc_base + part;
  end

  always_comb begin
    sum = $signed({cmd_r.ll[SW-1], cmd_r.ll}) + $signed({cmd_r.lr[SW-1], cmd_r.lr});
    dif = $signed({cmd_r.ll[SW-1], cmd_r.ll}) - $signed({cmd_r.lr[SW-1], cmd_r.lr});
    smin = (cmd_r.sl < cmd_r.sr) ? cmd_r.sl : cmd_r.sr;
    dec = !cmd_r.zero_den && (lhs_r >= rhs_r);
  end

  always_comb begin
    st_nxt = st_r;
    pp_nxt = pp_r;
    q_pop = 1'b0;
    ms_nxt = ms_r;
    seen_ms_nxt = seen_ms_r;
    seen_lr_nxt = seen_lr_r;
    ov_nxt = ov_r && out_stall;
    od_nxt = od_r;
    unique case (st_r)
      BK_IDLE: begin
        if (q_valid) begin
          q_pop = 1'b1;
          st_nxt = (q_data.func == FUNC_BAND) ? BK_P1 : BK_DONE;
        end
      end
      BK_P1: st_nxt = BK_P2;
      BK_P2: st_nxt = BK_LW;
      BK_LW: begin
        pp_nxt = pp_r + 2'd1;
        if (pp_r == 2'd3) st_nxt = BK_P3;
      end
      BK_P3: st_nxt = BK_P4;
      BK_P4: st_nxt = BK_RW;
      BK_RW: begin
        pp_nxt = pp_r + 2'd1;
        if (pp_r == 2'd3) st_nxt = BK_DONE;
      end
      BK_DONE: begin
        if (take) begin
          st_nxt = BK_IDLE;
          ov_nxt = 1'b1;
          od_nxt = '0;
          unique case (cmd_r.func)
            FUNC_BAND: begin
              ms_nxt = dec;
              if (dec) begin
                seen_ms_nxt = 1'b1;
                od_nxt.band_use_ms = 1'b1;
                od_nxt.thr_left_out = 32'(cmd_r.m);
                od_nxt.thr_right_out = 32'(cmd_r.m);
                od_nxt.energy_left_out = 32'(cmd_r.em);
                od_nxt.energy_right_out = 32'(cmd_r.es);
                od_nxt.spread_out = 32'(smin >> 1);
              end else begin
                seen_lr_nxt = 1'b1;
                od_nxt.thr_left_out = 32'(cmd_r.tl);
                od_nxt.thr_right_out = 32'(cmd_r.tr);
                od_nxt.energy_left_out = 32'(cmd_r.el);
                od_nxt.energy_right_out = 32'(cmd_r.er);
                od_nxt.spread_out = 32'(cmd_r.sl);
              end
            end
            FUNC_LINE: begin
              od_nxt.band_use_ms = ms_r;
              od_nxt.line_left_out = ms_r ? 32'($signed(sum[SW:1])) : 32'($signed(cmd_r.ll));
              od_nxt.line_right_out = ms_r ? 32'($signed(dif[SW:1])) : 32'($signed(cmd_r.lr));
            end
            FUNC_END: begin
              od_nxt.frame_mode = !seen_ms_r ? SEL_NONE : (seen_lr_r ? SEL_MIXED : SEL_ALL);
              ms_nxt = 1'b0;
              seen_ms_nxt = 1'b0;
              seen_lr_nxt = 1'b0;
            end
            default: od_nxt = '0;
          endcase
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= BK_IDLE;
      pp_r <= 2'd0;
      ms_r <= 1'b0;
      seen_ms_r <= 1'b0;
      seen_lr_r <= 1'b0;
      ov_r <= 1'b0;
    end else begin
      st_r <= st_nxt;
      pp_r <= pp_nxt;
      ms_r <= ms_nxt;
      seen_ms_r <= seen_ms_nxt;
      seen_lr_r <= seen_lr_nxt;
      ov_r <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    od_r <= od_nxt;
    if (q_pop) cmd_r <= q_data;
    unique case (st_r)
      BK_P1: p1_r <= p_nxt;
      BK_P2: p2_r <= p_nxt;
      BK_LW: lhs_r <= acc_nxt;
      BK_P3: p1_r <= p_nxt;
      BK_P4: p2_r <= p_nxt;
      BK_RW: rhs_r <= acc_nxt;
      BK_IDLE, BK_DONE: ;
    endcase
  end

  `ASSERT_CLK(a_hold, clk, rst_n, out_valid && out_stall |=> out_valid, "result dropped while stalled")
  `ASSERT_NEVER(a_pop_busy, clk, rst_n, q_pop && st_r != BK_IDLE, "pop while busy")
  `ASSERT_CLK(a_end_clr, clk, rst_n, st_r == BK_DONE && take && cmd_r.func == FUNC_END |=> !seen_ms_r && !seen_lr_r, "flags not cleared at end of frame")
endmodule
`default_nettype wire

/* sim/testbench.sv */
// ----------------------------------------------------------------------------
// Stereo band decision testbench
// Drives band, line, end and reserved requests through the stereo decision block,
// predicts every result from an independent model of the mid/side choice
// and compares each result field by field, under random sender and
// receiver idling and one long receiver hold-off.
// ----------------------------------------------------------------------------
module testbench;
  import mssbd_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int LIMIT = 400000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  in_item_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_item_t out_data;

  ms_stereo_band_decision_top dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
  );

  always #1 clk = ~clk;

  in_item_t pending_q[$];
  out_item_t expected_q[$];
  int fail_count = 0;
  int cycle_count = 0;
  int send_idle_pct = 13;
  int recv_idle_pct = 62;
  int holdoff_cycles = 0;
  bit holdoff_arm = 1'b0;
  bit holdoff_used = 1'b0;

  // Decision state of the predictor.
  bit cur_band_ms = 1'b0, frame_had_ms = 1'b0, frame_had_lr = 1'b0;

  function automatic out_item_t predict_result(in_item_t it);
    out_item_t r;
    logic [31:0] m, a, b, c, d;
    logic [127:0] lhs, rhs;
    logic signed [32:0] s, t;
    bit ms;
    r = '0;
    case (it.func)
      FUNC_BAND: begin
        m = (it.thr_left < it.thr_right) ? it.thr_left : it.thr_right;
        a = (it.energy_left > it.thr_left) ? it.energy_left : it.thr_left;
        b = (it.energy_right > it.thr_right) ? it.energy_right : it.thr_right;
        c = (it.energy_mid > m) ? it.energy_mid : m;
        d = (it.energy_side > m) ? it.energy_side : m;
        ms = 1'b0;
        if (a != 0 && b != 0 && c != 0 && d != 0) begin
          lhs = 128'(m) * 128'(m) * 128'(a) * 128'(b);
          rhs = 128'(it.thr_left) * 128'(it.thr_right) * 128'(c) * 128'(d);
          ms = lhs >= rhs;
        end
        cur_band_ms = ms;
        if (ms) begin
          frame_had_ms = 1'b1;
          r.band_use_ms = 1'b1;
          r.thr_left_out = m;
          r.thr_right_out = m;
          r.energy_left_out = it.energy_mid;
          r.energy_right_out = it.energy_side;
          r.spread_out = ((it.spread_left < it.spread_right) ?
                          it.spread_left : it.spread_right) >> 1;
        end else begin
          frame_had_lr = 1'b1;
          r.thr_left_out = it.thr_left;
          r.thr_right_out = it.thr_right;
          r.energy_left_out = it.energy_left;
          r.energy_right_out = it.energy_right;
          r.spread_out = it.spread_left;
        end
      end
      FUNC_LINE: begin
        r.band_use_ms = cur_band_ms;
        if (cur_band_ms) begin
          s = 33'(it.line_left) + 33'(it.line_right);
          t = 33'(it.line_left) - 33'(it.line_right);
          r.line_left_out = 32'(s >>> 1);
          r.line_right_out = 32'(t >>> 1);
        end else begin
          r.line_left_out = it.line_left;
          r.line_right_out = it.line_right;
        end
      end
      FUNC_END: begin
        r.frame_mode = !frame_had_ms ? SEL_NONE : (frame_had_lr ? SEL_MIXED : SEL_ALL);
        cur_band_ms = 1'b0;
        frame_had_ms = 1'b0;
        frame_had_lr = 1'b0;
      end
      default: ;
    endcase
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("MISMATCH %s: got %h, expected %h at cycle %0d", what, got, want,
             cycle_count);
    fail_count++;
  endtask

  // Driver: a request stays put until it is accepted.
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        expected_q.push_back(predict_result(in_data));
        if (pending_q.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          in_data <= pending_q.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end else if (!in_valid && pending_q.size() > 0 &&
                   $urandom_range(99) >= send_idle_pct) begin
        in_valid <= 1'b1;
        in_data <= pending_q.pop_front();
      end
    end
  end

  // Long receiver hold-off, armed once by the stimulus sequence.
  always @(posedge clk) begin
    if (holdoff_arm && !holdoff_used) begin
      holdoff_used <= 1'b1;
      holdoff_cycles <= 300;
    end else if (holdoff_cycles > 0) begin
      holdoff_cycles <= holdoff_cycles - 1;
    end
  end

  // Monitor and receiver stall.
  always @(posedge clk) begin
    out_item_t e;
    cycle_count <= cycle_count + 1;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_q.size() == 0) begin
        report_mismatch("unexpected result", '0, '0);
      end else begin
        e = expected_q.pop_front();
        if (out_data.band_use_ms != e.band_use_ms)
          report_mismatch("band_use_ms", 32'(out_data.band_use_ms), 32'(e.band_use_ms));
        if (out_data.thr_left_out != e.thr_left_out)
          report_mismatch("thr_left_out", out_data.thr_left_out, e.thr_left_out);
        if (out_data.thr_right_out != e.thr_right_out)
          report_mismatch("thr_right_out", out_data.thr_right_out, e.thr_right_out);
        if (out_data.energy_left_out != e.energy_left_out)
          report_mismatch("energy_left_out", out_data.energy_left_out, e.energy_left_out);
        if (out_data.energy_right_out != e.energy_right_out)
          report_mismatch("energy_right_out", out_data.energy_right_out,
                          e.energy_right_out);
        if (out_data.spread_out != e.spread_out)
          report_mismatch("spread_out", out_data.spread_out, e.spread_out);
        if (out_data.line_left_out != e.line_left_out)
          report_mismatch("line_left_out", out_data.line_left_out, e.line_left_out);
        if (out_data.line_right_out != e.line_right_out)
          report_mismatch("line_right_out", out_data.line_right_out, e.line_right_out);
        if (out_data.frame_mode != e.frame_mode)
          report_mismatch("frame_mode", 32'(out_data.frame_mode), 32'(e.frame_mode));
      end
    end
    if (holdoff_cycles > 0) begin
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  function automatic logic [31:0] pick_value();
    case ($urandom_range(5))
      0: return 32'h0;
      1: return 32'hFFFF_FFFF;
      2: return 32'($urandom_range(15));
      3: return 32'h8000_0000 | 32'($urandom_range(3));
      default: return $urandom();
    endcase
  endfunction

  function automatic in_item_t make_band(bit close_pair);
    in_item_t it;
    it = '0;
    it.func = FUNC_BAND;
    it.energy_left = pick_value();
    it.energy_right = pick_value();
    it.energy_mid = pick_value();
    it.energy_side = pick_value();
    it.thr_left = pick_value();
    it.thr_right = pick_value();
    // Near-equal thresholds make the decision go either way.
    if (close_pair) it.thr_right = it.thr_left + 32'($urandom_range(4));
    it.spread_left = pick_value();
    it.spread_right = pick_value();
    it.line_left = $urandom();
    it.line_right = $urandom();
    return it;
  endfunction

  function automatic in_item_t make_line();
    in_item_t it;
    it = '0;
    it.func = FUNC_LINE;
    it.line_left = pick_value();
    it.line_right = pick_value();
    it.energy_left = $urandom();
    return it;
  endfunction

  function automatic in_item_t make_end();
    in_item_t it;
    it = '0;
    it.func = FUNC_END;
    it.thr_left = $urandom();
    return it;
  endfunction

  task automatic queue_frames(int n_items);
    int added;
    int bands;
    int lines;
    in_item_t it;
    added = 0;
    while (added < n_items) begin
      bands = $urandom_range(1, 5);
      for (int i = 0; i < bands; i++) begin
        pending_q.push_back(make_band($urandom_range(1)));
        lines = $urandom_range(0, 4);
        for (int j = 0; j < lines; j++) pending_q.push_back(make_line());
        added += lines + 1;
        if ($urandom_range(19) == 0) begin
          it = make_band(1'b0);
          it.func = FUNC_RSVD;
          pending_q.push_back(it);
          added++;
        end
      end
      pending_q.push_back(make_end());
      added++;
    end
  endtask

  task automatic wait_drained();
    while (pending_q.size() > 0 || in_valid || expected_q.size() > 0)
      @(posedge clk);
  endtask

  always @(posedge clk) begin
    if (cycle_count > LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  initial begin
    in_item_t it;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: a line before any band, all-zero band, full-scale band,
    // a clear mid/side band with extreme lines, an unknown request, ends.
    pending_q.push_back(make_line());
    it = '0;
    pending_q.push_back(it);
    it = '1;
    it.func = FUNC_BAND;
    pending_q.push_back(it);
    it = '0;
    it.func = FUNC_BAND;
    it.energy_left = 32'd100; it.energy_right = 32'd100;
    it.energy_mid = 32'd1; it.energy_side = 32'd1;
    it.thr_left = 32'd10; it.thr_right = 32'd10;
    it.spread_left = 32'hFFFF_FFFF; it.spread_right = 32'd7;
    pending_q.push_back(it);
    it = '0; it.func = FUNC_LINE;
    it.line_left = 32'h7FFF_FFFF; it.line_right = 32'h7FFF_FFFF;
    pending_q.push_back(it);
    it.line_left = 32'h8000_0000; it.line_right = 32'h8000_0000;
    pending_q.push_back(it);
    it.line_left = 32'h7FFF_FFFF; it.line_right = 32'h8000_0000;
    pending_q.push_back(it);
    it.line_left = -32'sd3; it.line_right = 32'sd0;
    pending_q.push_back(it);
    it = '1; it.func = FUNC_RSVD;
    pending_q.push_back(it);
    pending_q.push_back(make_end());
    // Zero thresholds with nonzero energy: left/right with one side zero.
    it = '0; it.func = FUNC_BAND; it.energy_left = 32'd5;
    pending_q.push_back(it);
    pending_q.push_back(make_end());
    pending_q.push_back(make_end());
    wait_drained();

    queue_frames(400);
    wait_drained();

    send_idle_pct = 62;
    recv_idle_pct = 13;
    queue_frames(300);
    holdoff_arm = 1'b1;
    wait_drained();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    queue_frames(450);
    wait_drained();

    repeat (20) @(posedge clk);
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end
endmodule

/* ms_stereo_band_decision_top.f */
+incdir+hw/rtl
hw/rtl/mssbd_pkg.sv
hw/rtl/mssbd_front.sv
hw/rtl/mssbd_back.sv
hw/rtl/ms_stereo_band_decision_top.sv
sim/testbench.sv
